// ===== src/egcd_pkg.sv =====
// Package for the extended GCD block: default width and sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

    // Default operand width in bits
    localparam int DEF_WIDTH = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/extended_gcd.sv =====
// Extended GCD: gcd and Bezout coefficients of two signed operands.
//
// Usage:
//   Input channel: i_valid / o_stall with i_first_operand and i_second_operand.
//   A word is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_common_divisor, o_coeff_first and
//   o_coeff_second, so that gcd = a * coeff_first + b * coeff_second.
//   Each quotient step runs a WIDTH-bit restoring division, then an update
//   and a check; 32-bit operands need at most about 46 quotient steps.
//   The serial divide loop, which also accumulates both
//   quotient-times-coefficient products one bit per cycle, sets the run
//   time. One item is in work at a time.
//   Results sit in an output register: the block takes the next word while
//   a finished result still waits, but it cannot finish that next item until
//   the register is free. While i_stall is high the output word holds.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending output word.
`timescale 1ns / 1ps
`default_nettype none

module extended_gcd #(
    parameter int WIDTH = egcd_pkg::DEF_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [WIDTH-1:0] i_first_operand,
    input  wire logic signed [WIDTH-1:0] i_second_operand,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [WIDTH-2:0]             o_common_divisor,
    output logic signed [WIDTH-1:0]      o_coeff_first,
    output logic signed [WIDTH-1:0]      o_coeff_second
);

    import egcd_pkg::*;

    localparam int XW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH);

    t_state r_state, n_state;

    // Euclid state: operands as sign and magnitude, coefficients signed
    logic                 r_a_neg, r_b_neg;
    logic [WIDTH-1:0]     r_a_mag, r_b_mag;
    logic signed [XW-1:0] r_x, r_y, r_xn, r_yn;

    // Serial divider and product accumulators
    logic [WIDTH-1:0]     r_rem, r_quo;
    logic signed [XW-1:0] r_px, r_py;
    logic [CW-1:0]        r_cnt;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [WIDTH-2:0]     r_out_g;
    logic [WIDTH-1:0]     r_out_x, r_out_y;

    // Control strobes
    logic accept, ld_div, do_step, do_upd, out_free, out_wr;

    // Datapath wires
    logic                 in_a_neg, in_b_neg;
    logic [WIDTH-1:0]     in_a_mag, in_b_mag;
    logic [WIDTH+1:0]     trial;
    logic                 qbit;
    logic                 qneg, fin_neg;
    logic signed [XW-1:0] x_fin, y_fin;

    // Take magnitudes of the incoming operands
    always_comb begin
        in_a_neg = i_first_operand[WIDTH-1];
        in_b_neg = i_second_operand[WIDTH-1];
        in_a_mag = in_a_neg ? (~i_first_operand + 1'b1) : i_first_operand;
        in_b_mag = in_b_neg ? (~i_second_operand + 1'b1) : i_second_operand;
    end

    // Restoring division step on magnitudes
    always_comb begin
        trial = {1'b0, r_rem, r_quo[WIDTH-1]} - {2'b00, r_b_mag};
        qbit  = ~trial[WIDTH+1];
    end

    // Quotient sign and final sign fix
    always_comb begin
        qneg    = r_a_neg ^ r_b_neg;
        fin_neg = r_a_neg || (r_a_mag == '0);
        x_fin   = fin_neg ? -r_x : r_x;
        y_fin   = fin_neg ? -r_y : r_y;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (r_b_mag == '0) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_CHECK;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        o_stall  = (r_state != S_IDLE);
        accept   = (r_state == S_IDLE) && i_valid;
        ld_div   = (r_state == S_CHECK) && (r_b_mag != '0);
        do_step  = (r_state == S_DIV);
        do_upd   = (r_state == S_UPDATE);
        out_wr   = (r_state == S_DONE) && out_free;
    end

    // Output word valid: set on write, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_wr) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Euclid datapath: load, divide, update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_neg <= in_a_neg;
            r_a_mag <= in_a_mag;
            r_b_neg <= in_b_neg;
            r_b_mag <= in_b_mag;
            r_x     <= XW'(1);
            r_y     <= '0;
            r_xn    <= '0;
            r_yn    <= XW'(1);
        end
        if (ld_div) begin
            r_rem <= '0;
            r_quo <= r_a_mag;
            r_px  <= '0;
            r_py  <= '0;
            r_cnt <= CW'(WIDTH - 1);
        end
        if (do_step) begin
            r_rem <= qbit ? trial[WIDTH-1:0] : {r_rem[WIDTH-2:0], r_quo[WIDTH-1]};
            r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            r_px  <= (r_px <<< 1) + (qbit ? r_xn : '0);
            r_py  <= (r_py <<< 1) + (qbit ? r_yn : '0);
            r_cnt <= r_cnt - 1'b1;
        end
        // Advance: (a, b) <- (b, a mod b), coefficients shift down one row
        if (do_upd) begin
            r_a_neg <= r_b_neg;
            r_a_mag <= r_b_mag;
            r_b_neg <= r_a_neg;
            r_b_mag <= r_rem;
            r_x     <= r_xn;
            r_y     <= r_yn;
            r_xn    <= qneg ? (r_x + r_px) : (r_x - r_px);
            r_yn    <= qneg ? (r_y + r_py) : (r_y - r_py);
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out_g <= r_a_mag[WIDTH-2:0];
            r_out_x <= x_fin[WIDTH-1:0];
            r_out_y <= y_fin[WIDTH-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_common_divisor = r_out_g;
    assign o_coeff_first    = r_out_x;
    assign o_coeff_second   = r_out_y;

`ifndef SYNTHESIS
    // Division ends after the last quotient bit
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_UPDATE))
        else $error("divide loop did not hand over to update");

    // Remainder is below the divisor when the step completes
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (r_rem < r_b_mag))
        else $error("remainder not below divisor");

    // Operands shrink after every update
    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_b_mag < r_a_mag))
        else $error("Euclid step did not reduce operands");

    // A taken input word blocks the input until the item is done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && r_state == S_CHECK))
        else $error("input accepted but sequencer not started");
`endif

endmodule

`default_nettype wire

// ===== dv/extended_gcd_test.sv =====
// Self-checking testbench for the extended GCD block: directed and random operand words.
`timescale 1ns / 1ps

module extended_gcd_test;

    localparam int W = egcd_pkg::DEF_WIDTH;
    localparam longint POS_LIMIT = 64'sd2147483647;
    localparam longint NEG_LIMIT = -64'sd2147483648;
    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM = 400;
    localparam int DRAIN_CYCLES = 2000;

    // One result word: gcd and the two Bezout coefficients
    typedef struct {
        logic [W-2:0]        divisor;
        logic signed [W-1:0] coeff_a;
        logic signed [W-1:0] coeff_b;
    } t_gcd_word;

    // One directed row; known rows carry their result typed in
    typedef struct {
        longint a;
        longint b;
        bit     known;
        longint g;
        longint x;
        longint y;
    } t_operand_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic signed [W-1:0] i_first_operand = '0;
    logic signed [W-1:0] i_second_operand = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [W-2:0]        o_common_divisor;
    logic signed [W-1:0] o_coeff_first;
    logic signed [W-1:0] o_coeff_second;

    t_gcd_word    pending_results[$];
    t_gcd_word    oldest;
    int           mismatches = 0;
    int           burst_left = 0;
    int           stall_pct = 0;
    int           stall_window = 0;
    longint       fib[0:46];
    t_operand_row directed_rows[N_DIRECTED];

    extended_gcd #(.WIDTH(W)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_common_divisor (o_common_divisor),
        .o_coeff_first    (o_coeff_first),
        .o_coeff_second   (o_coeff_second)
    );

    always #10 i_clk = ~i_clk;

    // Run the Euclid iteration in 64-bit wrapping arithmetic, truncating quotients
    function automatic t_gcd_word bezout_of(logic signed [W-1:0] a_in,
                                            logic signed [W-1:0] b_in);
        longint r_prev, r_cur, s_prev, s_cur, t_prev, t_cur, quot, tmp;
        t_gcd_word res;
        r_prev = a_in;
        r_cur  = b_in;
        s_prev = 1;
        s_cur  = 0;
        t_prev = 0;
        t_cur  = 1;
        while (r_cur != 0) begin
            quot   = r_prev / r_cur;
            tmp    = r_prev - quot * r_cur;
            r_prev = r_cur;
            r_cur  = tmp;
            tmp    = s_prev - quot * s_cur;
            s_prev = s_cur;
            s_cur  = tmp;
            tmp    = t_prev - quot * t_cur;
            t_prev = t_cur;
            t_cur  = tmp;
        end
        // Flip all three when the last remainder is not positive
        if (r_prev <= 0) begin
            r_prev = -r_prev;
            s_prev = -s_prev;
            t_prev = -t_prev;
        end
        res.divisor = r_prev[W-2:0];
        res.coeff_a = s_prev[W-1:0];
        res.coeff_b = t_prev[W-1:0];
        return res;
    endfunction

    // Offer one operand word in bursts with random gaps, then queue its expected result
    task automatic send_word(longint a, longint b, t_gcd_word want);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(200, 1600);
                default: gap = $urandom_range(1, 40);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        i_valid          <= 1'b1;
        i_first_operand  <= a[W-1:0];
        i_second_operand <= b[W-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        pending_results.push_back(want);
    endtask

    // Draw a random operand pair from one of several shapes
    task automatic random_pair(output longint a, output longint b);
        logic signed [W-1:0] ra, rb;
        longint k;
        int idx;
        ra = $urandom;
        rb = $urandom;
        a  = ra;
        b  = rb;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: begin
                a = $urandom_range(0, 200);
                b = $urandom_range(0, 200);
            end
            4: begin
                k = $urandom_range(1, 5000);
                a = k * $urandom_range(0, 400000);
                b = k * $urandom_range(0, 400000);
            end
            5: begin
                if ($urandom_range(0, 1)) a = 0;
                else b = 0;
            end
            6: begin
                k = $urandom_range(1, 9);
                b = $urandom_range(0, 200000000);
                a = b * k;
            end
            default: begin
                idx = $urandom_range(1, 45);
                a = fib[idx + 1];
                b = fib[idx];
                if ($urandom_range(0, 1)) begin
                    k = a;
                    a = b;
                    b = k;
                end
            end
        endcase
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
    endtask

    // Compare each finished word with the oldest prediction; drive the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word: gcd %0d x %0d y %0d",
                         $time, o_common_divisor, o_coeff_first, o_coeff_second);
            end else begin
                oldest = pending_results.pop_front();
                if (o_common_divisor !== oldest.divisor) begin
                    mismatches++;
                    $display("%0t: gcd expected %0d actual %0d",
                             $time, oldest.divisor, o_common_divisor);
                end
                if (o_coeff_first !== oldest.coeff_a) begin
                    mismatches++;
                    $display("%0t: coeff_first expected %0d actual %0d",
                             $time, oldest.coeff_a, o_coeff_first);
                end
                if (o_coeff_second !== oldest.coeff_b) begin
                    mismatches++;
                    $display("%0t: coeff_second expected %0d actual %0d",
                             $time, oldest.coeff_b, o_coeff_second);
                end
            end
        end
        // Pick a new stall rate when the current window runs out, free-flowing windows included
        if (stall_window == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_window = $urandom_range(50, 400);
        end else begin
            stall_window--;
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Stimulus: reset, directed table, random words, drain
    initial begin
        t_gcd_word    want;
        t_operand_row row;
        longint       a, b;
        fib[0] = 0;
        fib[1] = 1;
        for (int i = 2; i <= 46; i++) fib[i] = fib[i - 1] + fib[i - 2];
        directed_rows = '{
            '{0, 0, 1'b1, 0, -1, 0},
            '{5, 0, 1'b1, 5, 1, 0},
            '{0, 5, 1'b1, 5, 0, 1},
            '{-5, 0, 1'b1, 5, -1, 0},
            '{0, -7, 1'b1, 7, 0, -1},
            '{1, 1, 1'b1, 1, 0, 1},
            '{POS_LIMIT, POS_LIMIT, 1'b1, POS_LIMIT, 0, 1},
            '{-POS_LIMIT, -POS_LIMIT, 1'b1, POS_LIMIT, 0, -1},
            '{POS_LIMIT, -POS_LIMIT, 1'b1, POS_LIMIT, 0, -1},
            '{NEG_LIMIT, 0, 1'b1, 0, -1, 0},
            '{0, NEG_LIMIT, 1'b1, 0, 0, -1},
            '{NEG_LIMIT, NEG_LIMIT, 1'b1, 0, 0, -1},
            '{NEG_LIMIT, POS_LIMIT, 1'b0, 0, 0, 0},
            '{POS_LIMIT, POS_LIMIT - 1, 1'b0, 0, 0, 0},
            '{1836311903, 1134903170, 1'b0, 0, 0, 0},
            '{-1134903170, 1836311903, 1'b0, 0, 0, 0},
            '{12, 18, 1'b0, 0, 0, 0},
            '{240, -46, 1'b0, 0, 0, 0},
            '{-240, -46, 1'b0, 0, 0, 0},
            '{1, POS_LIMIT, 1'b0, 0, 0, 0},
            '{POS_LIMIT, 1, 1'b0, 0, 0, 0},
            '{-1, -1, 1'b0, 0, 0, 0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.known) begin
                want.divisor = row.g[W-2:0];
                want.coeff_a = row.x[W-1:0];
                want.coeff_b = row.y[W-1:0];
            end else begin
                want = bezout_of(row.a[W-1:0], row.b[W-1:0]);
            end
            send_word(row.a, row.b, want);
        end

        // Random words checked against the predictor
        for (int i = 0; i < N_RANDOM; i++) begin
            random_pair(a, b);
            want = bezout_of(a[W-1:0], b[W-1:0]);
            send_word(a, b, want);
        end
        i_valid <= 1'b0;

        // Drain, then watch for stray words
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
src/egcd_pkg.sv
src/extended_gcd.sv
dv/extended_gcd_test.sv
